// ===== hw/rtl/odf_pkg.sv =====
package odf_pkg;

	// Kind codes reported with each result beat.
	typedef enum logic [2:0] {
		KIND_SIG      = 3'd0,
		KIND_HDR      = 3'd1,
		KIND_HDR_DONE = 3'd2,
		KIND_LACE     = 3'd3,
		KIND_PAY      = 3'd4,
		KIND_ERR      = 3'd5
	} kind_t;

	// Parser phases.
	typedef enum logic [2:0] {
		PH_SIG  = 3'd0,
		PH_HDR  = 3'd1,
		PH_LACE = 3'd2,
		PH_PAY  = 3'd3,
		PH_ERR  = 3'd4
	} phase_t;

	// Index of the segment-count byte, the last of the page header.
	localparam logic [4:0] HDR_LAST = 5'd22;

	// Header byte indexes where each held field starts.
	localparam logic [4:0] HDR_VERSION  = 5'd0;
	localparam logic [4:0] HDR_TYPE     = 5'd1;
	localparam logic [4:0] HDR_GRANULE  = 5'd2;
	localparam logic [4:0] HDR_SERIAL   = 5'd10;
	localparam logic [4:0] HDR_SEQUENCE = 5'd14;
	localparam logic [4:0] HDR_CRC      = 5'd18;

	// Depth of the queue between the classifier and the result stage.
	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	// One classified beat handed from the front to the back.
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic        eos;
		logic        eop;
		logic        counted;
		logic [4:0]  hdr_idx;
	} front_beat_t;

	function automatic logic [7:0] capture_byte(input logic [1:0] pos);
		logic [7:0] b;
		case (pos)
			2'd0: b = 8'h4F;
			2'd1: b = 8'h67;
			2'd2: b = 8'h67;
			2'd3: b = 8'h53;
			default: b = 8'h53;
		endcase
		return b;
	endfunction

endpackage

// ===== hw/rtl/ogg_page_deframer.sv =====
// Ogg page deframer.
// Input channel: one stream byte per beat on data_byte, with last_byte marking
// the final byte of a stream, under byte_valid / byte_ready.
// Output channel: one result beat per input beat under result_valid /
// result_ready: the byte's kind, the byte itself, segment and page end marks,
// the held page header fields and the running count of bytes not reported as errors.
// Throughput is one byte per cycle while the receiver takes every result. The
// phase sequencer classifies each byte combinationally, and the next segment
// length is prefetched from the lacing memory, so a segment boundary does not
// stall the input. Each accepted byte is registered in the two-entry queue
// and then in the output registers before it shows on result_valid.
// Reset clears the phase to the capture pattern, the error, the queue and all
// held fields and counters. The lacing memory needs no clearing.
// When the receiver stalls, the queue absorbs up to two more bytes, then
// byte_ready drops until the output register is taken.
module ogg_page_deframer #(
	parameter int MAX_SEGMENTS = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [2:0]  kind,
	output logic [7:0]  out_byte,
	output logic        end_of_segment,
	output logic        end_of_page,
	output logic [7:0]  version,
	output logic [7:0]  header_type,
	output logic [63:0] granule_position,
	output logic [31:0] serial_number,
	output logic [31:0] sequence_number,
	output logic [31:0] page_crc,
	output logic [7:0]  segment_count,
	output logic [31:0] bytes_consumed
);

	logic                 accept;
	logic                 q_valid;
	logic                 q_pop;
	odf_pkg::front_beat_t front_beat;
	odf_pkg::front_beat_t q_beat;

	assign accept = byte_valid && byte_ready;

	odf_front #(
		.MAX_SEGMENTS(MAX_SEGMENTS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.beat      (front_beat)
	);

	odf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.beat_in  (front_beat),
		.pop      (q_pop),
		.ready    (byte_ready),
		.valid    (q_valid),
		.beat_out (q_beat)
	);

	odf_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_valid          (q_valid),
		.q_beat           (q_beat),
		.q_pop            (q_pop),
		.result_valid     (result_valid),
		.result_ready     (result_ready),
		.kind             (kind),
		.out_byte         (out_byte),
		.end_of_segment   (end_of_segment),
		.end_of_page      (end_of_page),
		.version          (version),
		.header_type      (header_type),
		.granule_position (granule_position),
		.serial_number    (serial_number),
		.sequence_number  (sequence_number),
		.page_crc         (page_crc),
		.segment_count    (segment_count),
		.bytes_consumed   (bytes_consumed)
	);

	// Only payload bytes can close a segment.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && end_of_segment) |-> (kind == odf_pkg::KIND_PAY))
		else $error("end_of_segment on a non-payload beat");

	// A page can only end on the segment-count byte, a lacing byte or payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && end_of_page) |->
		(kind == odf_pkg::KIND_PAY || kind == odf_pkg::KIND_LACE ||
		 kind == odf_pkg::KIND_HDR_DONE))
		else $error("end_of_page on an unexpected beat kind");

	// The byte count only ever moves up by at most one per result.
	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (bytes_consumed == $past(bytes_consumed) ||
		          bytes_consumed == $past(bytes_consumed) + 32'd1))
		else $error("bytes_consumed moved by more than one");

endmodule

// ===== hw/rtl/odf_front.sv =====
module odf_front #(
	parameter int MAX_SEGMENTS = 255
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output odf_pkg::front_beat_t beat
);

	localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

	// Lengths of the nonempty segments after the first one, in page order.
	logic [7:0] lace_mem [MAX_SEGMENTS];

	odf_pkg::phase_t phase_q, phase_d;
	logic [4:0]      hdr_idx_q, hdr_idx_d;
	logic [7:0]      seg_idx_q, seg_idx_d;
	logic [7:0]      seg_cnt_q, seg_cnt_d;
	logic [7:0]      left_q, left_d;
	logic            have_first_q, have_first_d;
	logic [AW-1:0]   wptr_q, wptr_d;
	logic [AW-1:0]   rptr_q, rptr_d;
	logic [7:0]      rd_q;
	logic            mem_we;

	logic [1:0] sig_pos;
	logic       sig_match;
	logic       hdr_done;
	logic       lace_store;
	logic       lace_nz;
	logic       lace_last;
	logic       lace_any;
	logic       seg_end;
	logic       seg_more;

	assign sig_pos    = hdr_idx_q[1:0];
	assign sig_match  = data_byte == odf_pkg::capture_byte(sig_pos);
	assign hdr_done   = hdr_idx_q >= odf_pkg::HDR_LAST;
	assign lace_store = seg_idx_q < 8'(MAX_SEGMENTS);
	assign lace_nz    = lace_store && (data_byte != 8'd0);
	assign lace_last  = (9'(seg_idx_q) + 9'd1) >= 9'(seg_cnt_q);
	assign lace_any   = have_first_q || lace_nz;
	assign seg_end    = left_q <= 8'd1;
	assign seg_more   = rptr_q != wptr_q;

	// Next state.
	always_comb begin
		phase_d      = phase_q;
		hdr_idx_d    = hdr_idx_q;
		seg_idx_d    = seg_idx_q;
		seg_cnt_d    = seg_cnt_q;
		left_d       = left_q;
		have_first_d = have_first_q;
		wptr_d       = wptr_q;
		rptr_d       = rptr_q;
		mem_we       = 1'b0;
		if (accept) begin
			case (phase_q)
				odf_pkg::PH_SIG: begin
					if (!sig_match) begin
						phase_d = odf_pkg::PH_ERR;
					end else if (sig_pos == 2'd3) begin
						phase_d   = odf_pkg::PH_HDR;
						hdr_idx_d = 5'd0;
					end else begin
						hdr_idx_d = 5'(sig_pos) + 5'd1;
					end
				end
				odf_pkg::PH_HDR: begin
					if (hdr_done) begin
						hdr_idx_d    = 5'd0;
						seg_idx_d    = 8'd0;
						seg_cnt_d    = data_byte;
						have_first_d = 1'b0;
						wptr_d       = '0;
						rptr_d       = '0;
						phase_d      = (data_byte == 8'd0) ? odf_pkg::PH_SIG : odf_pkg::PH_LACE;
					end else begin
						hdr_idx_d = hdr_idx_q + 5'd1;
					end
				end
				odf_pkg::PH_LACE: begin
					// The first nonempty segment goes straight to the length counter,
					// later ones wait in the memory. Empty segments are dropped here.
					if (lace_nz) begin
						if (!have_first_q) begin
							left_d       = data_byte;
							have_first_d = 1'b1;
						end else begin
							mem_we = 1'b1;
							wptr_d = wptr_q + AW'(1);
						end
					end
					if (lace_last) begin
						if (lace_any) begin
							phase_d = odf_pkg::PH_PAY;
						end else begin
							phase_d   = odf_pkg::PH_SIG;
							hdr_idx_d = 5'd0;
						end
					end else begin
						seg_idx_d = seg_idx_q + 8'd1;
					end
				end
				odf_pkg::PH_PAY: begin
					if (!seg_end) begin
						left_d = left_q - 8'd1;
					end else if (seg_more) begin
						left_d = rd_q;
						rptr_d = rptr_q + AW'(1);
					end else begin
						left_d    = 8'd0;
						phase_d   = odf_pkg::PH_SIG;
						hdr_idx_d = 5'd0;
					end
				end
				default: begin
				end
			endcase
			if (last_byte) begin
				phase_d   = odf_pkg::PH_SIG;
				hdr_idx_d = 5'd0;
				seg_idx_d = 8'd0;
				left_d    = 8'd0;
			end
		end
	end

	// Classification of the current beat.
	always_comb begin
		beat.kind    = odf_pkg::KIND_ERR;
		beat.data    = data_byte;
		beat.eos     = 1'b0;
		beat.eop     = 1'b0;
		beat.counted = 1'b0;
		beat.hdr_idx = hdr_idx_q;
		case (phase_q)
			odf_pkg::PH_SIG: begin
				if (sig_match) begin
					beat.kind    = odf_pkg::KIND_SIG;
					beat.counted = 1'b1;
				end
			end
			odf_pkg::PH_HDR: begin
				beat.kind    = hdr_done ? odf_pkg::KIND_HDR_DONE : odf_pkg::KIND_HDR;
				beat.counted = 1'b1;
				beat.eop     = hdr_done && (data_byte == 8'd0);
			end
			odf_pkg::PH_LACE: begin
				beat.kind    = odf_pkg::KIND_LACE;
				beat.counted = 1'b1;
				beat.eop     = lace_last && !lace_any;
			end
			odf_pkg::PH_PAY: begin
				beat.kind    = odf_pkg::KIND_PAY;
				beat.counted = 1'b1;
				beat.eos     = seg_end;
				beat.eop     = seg_end && !seg_more;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= odf_pkg::PH_SIG;
			hdr_idx_q    <= 5'd0;
			seg_idx_q    <= 8'd0;
			seg_cnt_q    <= 8'd0;
			left_q       <= 8'd0;
			have_first_q <= 1'b0;
			wptr_q       <= '0;
			rptr_q       <= '0;
		end else begin
			phase_q      <= phase_d;
			hdr_idx_q    <= hdr_idx_d;
			seg_idx_q    <= seg_idx_d;
			seg_cnt_q    <= seg_cnt_d;
			left_q       <= left_d;
			have_first_q <= have_first_d;
			wptr_q       <= wptr_d;
			rptr_q       <= rptr_d;
		end
	end

	// The read register always holds the entry at the read pointer, so the next
	// segment length is ready the cycle a segment ends. A same-cycle write to
	// that entry is forwarded.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			lace_mem[wptr_q] <= data_byte;
		end
		if (mem_we && (wptr_q == rptr_d)) begin
			rd_q <= data_byte;
		end else begin
			rd_q <= lace_mem[rptr_d];
		end
	end

endmodule

// ===== hw/rtl/odf_queue.sv =====
module odf_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  odf_pkg::front_beat_t beat_in,
	input  logic                 pop,
	output logic                 ready,
	output logic                 valid,
	output odf_pkg::front_beat_t beat_out
);

	odf_pkg::front_beat_t        entries [odf_pkg::QDEPTH];
	logic [odf_pkg::QAW-1:0]     wr_q;
	logic [odf_pkg::QAW-1:0]     rd_q;
	logic [odf_pkg::QCW-1:0]     count_q;

	assign ready    = count_q != odf_pkg::QCW'(odf_pkg::QDEPTH);
	assign valid    = count_q != '0;
	assign beat_out = entries[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + odf_pkg::QAW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + odf_pkg::QAW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + odf_pkg::QCW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - odf_pkg::QCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries[wr_q] <= beat_in;
		end
	end

endmodule

// ===== hw/rtl/odf_back.sv =====
module odf_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  odf_pkg::front_beat_t q_beat,
	output logic                 q_pop,
	output logic                 result_valid,
	input  logic                 result_ready,
	output logic [2:0]           kind,
	output logic [7:0]           out_byte,
	output logic                 end_of_segment,
	output logic                 end_of_page,
	output logic [7:0]           version,
	output logic [7:0]           header_type,
	output logic [63:0]          granule_position,
	output logic [31:0]          serial_number,
	output logic [31:0]          sequence_number,
	output logic [31:0]          page_crc,
	output logic [7:0]           segment_count,
	output logic [31:0]          bytes_consumed
);

	logic            valid_q;
	odf_pkg::kind_t  kind_q;
	logic [7:0]      byte_q;
	logic            eos_q;
	logic            eop_q;
	logic [7:0]      version_q;
	logic [7:0]      type_q;
	logic [63:0]     granule_q;
	logic [31:0]     serial_q;
	logic [31:0]     sequence_q;
	logic [31:0]     crc_q;
	logic [7:0]      seg_count_q;
	logic [31:0]     total_q;

	logic        hdr_write;
	logic [2:0]  g_off;
	logic [1:0]  s_off;
	logic [1:0]  n_off;
	logic [1:0]  c_off;

	// The held header fields double as the output registers: they change only
	// when the output slot is free or being taken.
	assign q_pop     = q_valid && (!valid_q || result_ready);
	assign hdr_write = q_pop && q_beat.counted &&
		(q_beat.kind == odf_pkg::KIND_HDR || q_beat.kind == odf_pkg::KIND_HDR_DONE);
	assign g_off     = 3'(q_beat.hdr_idx - odf_pkg::HDR_GRANULE);
	assign s_off     = 2'(q_beat.hdr_idx - odf_pkg::HDR_SERIAL);
	assign n_off     = 2'(q_beat.hdr_idx - odf_pkg::HDR_SEQUENCE);
	assign c_off     = 2'(q_beat.hdr_idx - odf_pkg::HDR_CRC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			version_q   <= 8'd0;
			type_q      <= 8'd0;
			granule_q   <= 64'd0;
			serial_q    <= 32'd0;
			sequence_q  <= 32'd0;
			crc_q       <= 32'd0;
			seg_count_q <= 8'd0;
			total_q     <= 32'd0;
		end else begin
			if (q_pop) begin
				valid_q <= 1'b1;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
			if (hdr_write) begin
				case (q_beat.hdr_idx) inside
					odf_pkg::HDR_VERSION: version_q <= q_beat.data;
					odf_pkg::HDR_TYPE:    type_q    <= q_beat.data;
					[odf_pkg::HDR_GRANULE:odf_pkg::HDR_SERIAL - 5'd1]: begin
						granule_q[{g_off, 3'b000} +: 8] <= q_beat.data;
					end
					[odf_pkg::HDR_SERIAL:odf_pkg::HDR_SEQUENCE - 5'd1]: begin
						serial_q[{s_off, 3'b000} +: 8] <= q_beat.data;
					end
					[odf_pkg::HDR_SEQUENCE:odf_pkg::HDR_CRC - 5'd1]: begin
						sequence_q[{n_off, 3'b000} +: 8] <= q_beat.data;
					end
					[odf_pkg::HDR_CRC:odf_pkg::HDR_LAST - 5'd1]: begin
						crc_q[{c_off, 3'b000} +: 8] <= q_beat.data;
					end
					default:       seg_count_q <= q_beat.data;
				endcase
			end
			if (q_pop && q_beat.counted && (total_q != '1)) begin
				total_q <= total_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_q <= q_beat.kind;
			byte_q <= q_beat.data;
			eos_q  <= q_beat.eos;
			eop_q  <= q_beat.eop;
		end
	end

	assign result_valid     = valid_q;
	assign kind             = kind_q;
	assign out_byte         = byte_q;
	assign end_of_segment   = eos_q;
	assign end_of_page      = eop_q;
	assign version          = version_q;
	assign header_type      = type_q;
	assign granule_position = granule_q;
	assign serial_number    = serial_q;
	assign sequence_number  = sequence_q;
	assign page_crc         = crc_q;
	assign segment_count    = seg_count_q;
	assign bytes_consumed   = total_q;

endmodule
